>>> rtl/set_assoc_lru_icache_tags_defines.svh
// assertion macros for the icache tag store checker
// no dependencies
`ifndef SET_ASSOC_LRU_ICACHE_TAGS_DEFINES_SVH
`define SET_ASSOC_LRU_ICACHE_TAGS_DEFINES_SVH
// clocked assertion with reset disable
`define ICT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// signal holds its value on the cycle after cond
`define ICT_ASSERT_STABLE(lbl, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) cond |=> $stable(sig)) \
		else $error(msg);
`endif

>>> rtl/ict_pkg.sv
// shared types, constants and helpers of the icache tag store
// no dependencies
`timescale 1ns / 1ps
package ict_pkg;
	localparam int SET_COUNT_DEF    = 64;
	localparam int WAY_COUNT_DEF    = 8;
	localparam int LINE_BYTES_DEF   = 64;
	localparam int ADDRESS_BITS_DEF = 48;
	localparam int CNT_W            = 32;
	localparam int BLOCK_SHIFT      = 4;

	typedef enum logic [1:0] {
		OP_FILL,
		OP_FILL_MRU,
		OP_MRU
	} set_op_t;

	typedef struct packed {
		logic hit;
		logic evict;
	} set_stat_t;

	function automatic int min1_clog2(input int v);
		return (v > 1) ? $clog2(v) : 1;
	endfunction

	function automatic int byte_pad(input int v);
		return ((v + 7) / 8) * 8;
	endfunction
endpackage

>>> rtl/ict_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module ict_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/ict_set_unit.sv
// shared set update unit: lookup, lru fill and mru promotion of one set row
// depends on ict_pkg
`timescale 1ns / 1ps
module ict_set_unit #(
	parameter int WAYS = 8,
	parameter int RB   = 3,
	parameter int TB   = 36,
	localparam int RW  = WAYS * (1 + RB + TB)
) (
	input  ict_pkg::set_op_t  op,
	input  logic [TB-1:0]     tag,
	input  logic [RW-1:0]     row_in,
	output logic [RW-1:0]     row_out,
	output ict_pkg::set_stat_t stat,
	output logic [TB-1:0]     evict_tag
);
	import ict_pkg::*;

	logic [WAYS-1:0]   vld, vld_n, match, full_rank;
	logic [RB-1:0]     rank [WAYS];
	logic [RB-1:0]     rank_n [WAYS];
	logic [TB-1:0]     tg [WAYS];
	logic [TB-1:0]     tg_n [WAYS];
	logic [RB-1:0]     hit_rank;
	logic              hit, full, do_fill, do_mru, got_slot, got_hit;
	logic [WAYS-1:0]   slot_oh, victim_oh;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			vld[w]  = row_in[w];
			rank[w] = row_in[WAYS + w*RB +: RB];
			tg[w]   = row_in[WAYS*(1+RB) + w*TB +: TB];
			match[w] = vld[w] && (tg[w] == tag);
			full_rank[w] = (rank[w] == RB'(WAYS - 1));
		end
		hit  = |match;
		full = &vld;
		hit_rank = '0;
		got_hit = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if (match[w] && !got_hit) begin
				hit_rank = rank[w];
				got_hit = 1'b1;
			end
		end
		victim_oh = '0;
		slot_oh = '0;
		got_slot = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if (full) begin
				if (full_rank[w] && !got_slot) begin
					victim_oh[w] = 1'b1;
					slot_oh[w] = 1'b1;
					got_slot = 1'b1;
				end
			end else if (!vld[w] && !got_slot) begin
				slot_oh[w] = 1'b1;
				got_slot = 1'b1;
			end
		end
		do_fill = !hit && (op != OP_MRU);
		do_mru  = hit && (op != OP_FILL);
		evict_tag = '0;
		for (int w = 0; w < WAYS; w++) begin
			vld_n[w]  = vld[w];
			rank_n[w] = rank[w];
			tg_n[w]   = tg[w];
			if (do_fill) begin
				if (slot_oh[w]) begin
					vld_n[w] = 1'b1;
					rank_n[w] = '0;
					tg_n[w] = tag;
				end else if (vld[w]) begin
					rank_n[w] = rank[w] + 1'b1;
				end
				if (victim_oh[w]) begin
					evict_tag = tg[w];
				end
			end else if (do_mru) begin
				if (match[w]) begin
					rank_n[w] = '0;
				end else if (vld[w] && rank[w] < hit_rank) begin
					rank_n[w] = rank[w] + 1'b1;
				end
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			row_out[w] = vld_n[w];
			row_out[WAYS + w*RB +: RB] = rank_n[w];
			row_out[WAYS*(1+RB) + w*TB +: TB] = tg_n[w];
		end
		stat.hit   = hit;
		stat.evict = do_fill && full;
	end
endmodule

>>> rtl/set_assoc_lru_icache_tags.sv
// set-associative true-lru instruction cache tag store, top level
// depends on ict_pkg, ict_ram, ict_set_unit
// a skipped fetch goes straight to done; a request reads and updates the demand set,
// with prefetch then the prefetch set and the demand set again; one word at a time
// each set access is a ram read followed by a read-modify-write in the unit
// reset: counters, previous block and prefetch mode clear; then a clearing
// pass zeroes every set row, tags too, before words are taken
`timescale 1ns / 1ps
module set_assoc_lru_icache_tags #(
	parameter int SET_COUNT    = ict_pkg::SET_COUNT_DEF,
	parameter int WAY_COUNT    = ict_pkg::WAY_COUNT_DEF,
	parameter int LINE_BYTES   = ict_pkg::LINE_BYTES_DEF,
	parameter int ADDRESS_BITS = ict_pkg::ADDRESS_BITS_DEF,
	localparam int OFF = $clog2(LINE_BYTES),
	localparam int SB  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1,
	localparam int SH  = OFF + ((SET_COUNT > 1) ? $clog2(SET_COUNT) : 0),
	localparam int TB  = ADDRESS_BITS - SH,
	localparam int RB  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1,
	localparam int IW  = ict_pkg::byte_pad(ADDRESS_BITS),
	localparam int OFW = 5 + TB + SB + 3 * ict_pkg::CNT_W,
	localparam int OW  = ict_pkg::byte_pad(OFW)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [IW-1:0] s_tdata,  // fetch_address
	output logic          m_tvalid,
	input  logic          m_tready,
	// skipped, hit, evicted, evicted_tag, set_index, prefetch_filled,
	// prefetch_evicted, request_count, miss_count, replacement_count
	output logic [OW-1:0] m_tdata,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);
	import ict_pkg::*;

	localparam int RW = WAY_COUNT * (1 + RB + TB);
	localparam int BW = ADDRESS_BITS - BLOCK_SHIFT;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_RD_D, ST_LK_D, ST_RD_P, ST_LK_P, ST_RD_M, ST_LK_M, ST_DONE
	} state_t;

	state_t              state_q;
	logic [SB-1:0]       clr_q, dset_q, pset_q, raddr;
	logic [TB-1:0]       dtag_q, ptag_q, cur_tag, ev_tag, ev_tag_q;
	logic [BW-1:0]       prev_q;
	logic                prev_vld_q, pf_mode_q, skip_q, hit_q, ev_q, pf_fill_q, pf_ev_q;
	logic [CNT_W-1:0]    req_q, miss_q, repl_q;
	logic [RW-1:0]       rdata, row_new, wdata;
	logic [SB-1:0]       waddr;
	logic                we;
	set_op_t             op;
	set_stat_t           stat;
	logic [ADDRESS_BITS-1:0] addr, paddr;
	logic [SB-1:0]       set_a, set_p;

	assign addr  = s_tdata[ADDRESS_BITS-1:0];
	assign paddr = addr + ADDRESS_BITS'(LINE_BYTES);
	assign set_a = (SET_COUNT > 1) ? addr[OFF +: SB] : '0;
	assign set_p = (SET_COUNT > 1) ? paddr[OFF +: SB] : '0;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);

	always_comb begin
		unique case (state_q)
			ST_LK_D: op = pf_mode_q ? OP_FILL : OP_FILL_MRU;
			ST_LK_P: op = OP_FILL;
			default: op = OP_MRU;
		endcase
	end

	assign cur_tag = (state_q == ST_LK_P) ? ptag_q : dtag_q;
	assign raddr   = (state_q == ST_RD_P) ? pset_q : dset_q;
	assign we      = (state_q == ST_CLR) || (state_q == ST_LK_D) ||
	                 (state_q == ST_LK_P) || (state_q == ST_LK_M);
	assign waddr   = (state_q == ST_CLR) ? clr_q : ((state_q == ST_LK_P) ? pset_q : dset_q);
	assign wdata   = (state_q == ST_CLR) ? '0 : row_new;

	ict_ram #(.WIDTH(RW), .DEPTH(SET_COUNT)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	ict_set_unit #(.WAYS(WAY_COUNT), .RB(RB), .TB(TB)) u_unit (
		.op        (op),
		.tag       (cur_tag),
		.row_in    (rdata),
		.row_out   (row_new),
		.stat      (stat),
		.evict_tag (ev_tag)
	);

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (&c) ? c : c + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			prev_vld_q <= 1'b0;
			prev_q     <= '0;
			pf_mode_q  <= 1'b0;
			req_q      <= '0;
			miss_q     <= '0;
			repl_q     <= '0;
			m_tvalid   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pf_mode_q <= cfg_data;
			end
			if (m_tvalid && m_tready && (state_q != ST_DONE)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SB'(SET_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						dset_q    <= set_a;
						pset_q    <= set_p;
						dtag_q    <= addr[ADDRESS_BITS-1 -: TB];
						ptag_q    <= paddr[ADDRESS_BITS-1 -: TB];
						hit_q     <= 1'b0;
						ev_q      <= 1'b0;
						ev_tag_q  <= '0;
						pf_fill_q <= 1'b0;
						pf_ev_q   <= 1'b0;
						prev_q    <= addr[ADDRESS_BITS-1:BLOCK_SHIFT];
						prev_vld_q <= 1'b1;
						if (prev_vld_q && prev_q == addr[ADDRESS_BITS-1:BLOCK_SHIFT]) begin
							skip_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							skip_q  <= 1'b0;
							req_q   <= sat_inc(req_q);
							state_q <= ST_RD_D;
						end
					end
				end
				ST_RD_D: state_q <= ST_LK_D;
				ST_LK_D: begin
					hit_q <= stat.hit;
					if (!stat.hit) begin
						miss_q <= sat_inc(miss_q);
					end
					if (stat.evict) begin
						ev_q     <= 1'b1;
						ev_tag_q <= ev_tag;
						repl_q   <= sat_inc(repl_q);
					end
					state_q <= pf_mode_q ? ST_RD_P : ST_DONE;
				end
				ST_RD_P: state_q <= ST_LK_P;
				ST_LK_P: begin
					pf_fill_q <= !stat.hit;
					if (stat.evict) begin
						pf_ev_q <= 1'b1;
						repl_q  <= sat_inc(repl_q);
					end
					state_q <= ST_RD_M;
				end
				ST_RD_M: state_q <= ST_LK_M;
				ST_LK_M: state_q <= ST_DONE;
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= OW'({repl_q, miss_q, req_q, pf_ev_q, pf_fill_q,
						                 skip_q ? SB'(0) : dset_q, ev_tag_q, ev_q, hit_q,
						                 skip_q});
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/ict_checker.sv
// port-level checker for the icache tag store, with its bind
// depends on set_assoc_lru_icache_tags_defines.svh
`timescale 1ns / 1ps
`include "set_assoc_lru_icache_tags_defines.svh"
module ict_checker #(
	parameter int IW = 48,
	parameter int OW = 144
) (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic [IW-1:0] s_tdata,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [OW-1:0] m_tdata
);
	`ICT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "output word dropped")
	`ICT_ASSERT_STABLE(a_out_stable, m_tvalid && !m_tready, m_tdata, "output word changed")
	`ICT_ASSERT(a_busy, s_tvalid && s_tready |=> !s_tready, "word taken while busy")
	`ICT_ASSERT(a_ev_miss, m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[0], "evict on hit")
endmodule

bind set_assoc_lru_icache_tags ict_checker #(.IW(IW), .OW(OW)) u_ict_checker (.*);
